>>> rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 matrix-vector transform: lane
// geometry, Q8.8 limits, register indexes and the identity reset matrix.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // Geometry: four rows, four columns, signed Q8.8 operands and results
   localparam int LANES    = 4;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = 2 * COEF_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int FRAC_W   = 8;
   localparam int SHR_W    = SUM_W - FRAC_W;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = LANES * COEF_W;

   // Saturation limits of the Q8.8 result
   localparam logic [COEF_W-1:0] Q_MAX_C = 16'h7FFF;
   localparam logic [COEF_W-1:0] Q_MIN_C = 16'h8000;

   // One row holds four coefficients, column 0 in the low lane
   typedef logic [LANES-1:0][COEF_W-1:0] row_type;
   typedef row_type [LANES-1:0] matrix_type;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_ROW_0,
      REG_ROW_1,
      REG_ROW_2,
      REG_ROW_3
   } reg_index_type;

   // Identity matrix: 1.0 (0x0100) on the diagonal
   localparam row_type ROW_0_RESET_C = 64'h0000_0000_0000_0100;
   localparam row_type ROW_1_RESET_C = 64'h0000_0000_0100_0000;
   localparam row_type ROW_2_RESET_C = 64'h0000_0100_0000_0000;
   localparam row_type ROW_3_RESET_C = 64'h0100_0000_0000_0000;

   // Pipeline advance controls handed to every lane
   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } pipe_ctl_type;

   // One lane's finished component
   typedef struct packed {
      logic [COEF_W-1:0] value;
      logic              sat;
   } lane_result_type;

   typedef lane_result_type [LANES-1:0] lane_results_type;

endpackage

>>> rtl/mvt_csr.sv
// ----------------------------------------------------------------------------
// mvt_csr
// Configuration registers: four 64-bit matrix rows on an APB-style port,
// resetting to the identity matrix.
// ----------------------------------------------------------------------------
module mvt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mvt_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [mvt_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [mvt_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output mvt_pkg::matrix_type           matrix
);

   mvt_pkg::matrix_type    matrix_ff;
   mvt_pkg::matrix_type    matrix_in;
   mvt_pkg::reg_index_type index;
   logic                   write_en;

   // Decode the row from the 8-byte register slot
   assign index      = mvt_pkg::reg_index_type'(csr_paddr[mvt_pkg::ADDR_W-1:3]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Update the addressed row on the access cycle of a write
   always_comb begin
      matrix_in = matrix_ff;
      if (write_en) begin
         case (index)
            mvt_pkg::REG_ROW_0: matrix_in[0] = csr_pwdata;
            mvt_pkg::REG_ROW_1: matrix_in[1] = csr_pwdata;
            mvt_pkg::REG_ROW_2: matrix_in[2] = csr_pwdata;
            mvt_pkg::REG_ROW_3: matrix_in[3] = csr_pwdata;
            default:            matrix_in    = matrix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0] <= mvt_pkg::ROW_0_RESET_C;
         matrix_ff[1] <= mvt_pkg::ROW_1_RESET_C;
         matrix_ff[2] <= mvt_pkg::ROW_2_RESET_C;
         matrix_ff[3] <= mvt_pkg::ROW_3_RESET_C;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   // Return the addressed row on reads
   always_comb begin
      case (index)
         mvt_pkg::REG_ROW_0: csr_prdata = matrix_ff[0];
         mvt_pkg::REG_ROW_1: csr_prdata = matrix_ff[1];
         mvt_pkg::REG_ROW_2: csr_prdata = matrix_ff[2];
         mvt_pkg::REG_ROW_3: csr_prdata = matrix_ff[3];
         default:            csr_prdata = '0;
      endcase
   end

   assign matrix = matrix_ff;

endmodule

>>> rtl/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane
// One row of the transform: four signed 16x16 products in the first stage,
// then the exact sum, floor shift by 8 and Q8.8 saturation in the second.
// ----------------------------------------------------------------------------
module mvt_lane (
   input  logic                      clock,
   input  mvt_pkg::pipe_ctl_type     ctl,
   input  mvt_pkg::row_type          row,
   input  mvt_pkg::row_type          vec,
   output mvt_pkg::lane_result_type  result
);

   logic signed [mvt_pkg::PROD_W-1:0] prod_ff [mvt_pkg::LANES];
   logic signed [mvt_pkg::PROD_W-1:0] prod_in [mvt_pkg::LANES];
   logic signed [mvt_pkg::SUM_W-1:0]  sum;
   logic signed [mvt_pkg::SHR_W-1:0]  shr;
   logic                              sat_hi;
   logic                              sat_lo;
   mvt_pkg::lane_result_type          result_ff;
   mvt_pkg::lane_result_type          result_in;

   // Multiply each coefficient by its vector component
   always_comb begin
      for (int c = 0; c < mvt_pkg::LANES; c++) begin
         prod_in[c] = $signed(row[c]) * $signed(vec[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         prod_ff <= prod_in;
      end
   end

   // Sum the products exactly in Q18.16
   always_comb begin
      sum = '0;
      for (int c = 0; c < mvt_pkg::LANES; c++) begin
         sum = sum + mvt_pkg::SUM_W'(prod_ff[c]);
      end
   end

   // Drop the low fraction bits (floor) and clamp to Q8.8
   assign shr    = sum[mvt_pkg::SUM_W-1:mvt_pkg::FRAC_W];
   assign sat_hi = !shr[mvt_pkg::SHR_W-1] &&
                   (shr[mvt_pkg::SHR_W-2:mvt_pkg::COEF_W-1] != '0);
   assign sat_lo = shr[mvt_pkg::SHR_W-1] &&
                   (shr[mvt_pkg::SHR_W-2:mvt_pkg::COEF_W-1] != '1);

   always_comb begin
      result_in.sat = sat_hi || sat_lo;
      if (sat_hi) begin
         result_in.value = mvt_pkg::Q_MAX_C;
      end else if (sat_lo) begin
         result_in.value = mvt_pkg::Q_MIN_C;
      end else begin
         result_in.value = shr[mvt_pkg::COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/mvt_merge.sv
// ----------------------------------------------------------------------------
// mvt_merge
// Output stage: gathers the four lane results, combines their saturation
// flags and holds the finished transfer until the consumer takes it.
// ----------------------------------------------------------------------------
module mvt_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           lanes_valid,
   input  mvt_pkg::lane_results_type      lanes,
   output logic                           out_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mvt_pkg::COEF_W-1:0]     rsp_out_x,
   output logic [mvt_pkg::COEF_W-1:0]     rsp_out_y,
   output logic [mvt_pkg::COEF_W-1:0]     rsp_out_z,
   output logic [mvt_pkg::COEF_W-1:0]     rsp_out_w,
   output logic                           rsp_saturated
);

   logic                      valid_ff;
   logic                      valid_in;
   logic                      load;
   logic                      sat_any;
   mvt_pkg::lane_results_type lanes_ff;
   logic                      sat_ff;

   // The slot frees when empty or when its transfer completes this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign load     = lanes_valid && out_free;
   assign valid_in = out_free ? lanes_valid : valid_ff;

   // Flag the item if any lane clamped
   always_comb begin
      sat_any = 1'b0;
      for (int r = 0; r < mvt_pkg::LANES; r++) begin
         sat_any = sat_any || lanes[r].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lanes_ff <= lanes;
         sat_ff   <= sat_any;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_x     = lanes_ff[0].value;
   assign rsp_out_y     = lanes_ff[1].value;
   assign rsp_out_z     = lanes_ff[2].value;
   assign rsp_out_w     = lanes_ff[3].value;
   assign rsp_saturated = sat_ff;

endmodule

>>> rtl/matrix_vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Streams signed Q8.8 4-component vectors through a configurable 4x4 matrix.
// ----------------------------------------------------------------------------
// Takes one vector per clock and delivers one transformed vector per clock
// while rsp_stall is low; each passes the product, sum-and-saturate and
// output registers. The rate comes from sixteen 16x16 multipliers in four
// row lanes side by side, one per coefficient. Each result component is
// row r of the matrix dotted with the vector, summed exactly, floored by
// 8 bits and clamped to Q8.8; rsp_saturated marks a clamped item. Rows are
// 64-bit registers at byte addresses 0, 8, 16, 24 (column 0 in bits 15:0)
// and reset to identity; rewrite them only while no items are in flight.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 (
   input  logic                          clock,
   input  logic                          reset,
   // input vectors
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_in_x,
   input  logic signed [15:0]            req_in_y,
   input  logic signed [15:0]            req_in_z,
   input  logic signed [15:0]            req_in_w,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_out_x,
   output logic signed [15:0]            rsp_out_y,
   output logic signed [15:0]            rsp_out_z,
   output logic signed [15:0]            rsp_out_w,
   output logic                          rsp_saturated,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mvt_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [mvt_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [mvt_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   mvt_pkg::matrix_type        matrix;
   mvt_pkg::row_type           vec;
   mvt_pkg::pipe_ctl_type      ctl;
   mvt_pkg::lane_results_type  lanes;
   logic                       v1_ff;
   logic                       v1_in;
   logic                       v2_ff;
   logic                       v2_in;
   logic                       s1_free;
   logic                       s2_free;
   logic                       out_free;
   logic [15:0]                out_x;
   logic [15:0]                out_y;
   logic [15:0]                out_z;
   logic [15:0]                out_w;

   // Configuration registers
   mvt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .matrix      (matrix)
   );

   // Pack the vector with component 0 in the low lane
   assign vec = {req_in_w, req_in_z, req_in_y, req_in_x};

   // Advance each stage when it is empty or the one after it moves
   assign s2_free     = !v2_ff || out_free;
   assign s1_free     = !v1_ff || s2_free;
   assign req_stall   = !s1_free;
   assign ctl.load_s1 = req_valid && s1_free;
   assign ctl.load_s2 = v1_ff && s2_free;
   assign v1_in       = s1_free ? req_valid : v1_ff;
   assign v2_in       = s2_free ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // One lane per matrix row
   for (genvar r = 0; r < mvt_pkg::LANES; r++) begin : g_lane
      mvt_lane u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .row    (matrix[r]),
         .vec    (vec),
         .result (lanes[r])
      );
   end

   // Combine the lanes into the output transfer
   mvt_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .lanes_valid   (v2_ff),
      .lanes         (lanes),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (out_x),
      .rsp_out_y     (out_y),
      .rsp_out_z     (out_z),
      .rsp_out_w     (out_w),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_out_x = $signed(out_x);
   assign rsp_out_y = $signed(out_y);
   assign rsp_out_z = $signed(out_z);
   assign rsp_out_w = $signed(out_w);

   // Input stalls only when every stage holds an item and the output waits
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // A finished item moves into an empty output slot at once
   a_drain_to_output: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rsp_valid) |=> rsp_valid)
      else $error("stage two item did not reach the output");

   // A flagged result carries at least one clamped component
   a_sat_has_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (out_x == mvt_pkg::Q_MAX_C || out_x == mvt_pkg::Q_MIN_C ||
          out_y == mvt_pkg::Q_MAX_C || out_y == mvt_pkg::Q_MIN_C ||
          out_z == mvt_pkg::Q_MAX_C || out_z == mvt_pkg::Q_MIN_C ||
          out_w == mvt_pkg::Q_MAX_C || out_w == mvt_pkg::Q_MIN_C))
      else $error("saturation flag without a clamped component");

endmodule
